>>> hdl/lcpt_pkg.sv
// Shared types and constants for the layer/category pair table.
// Used by lcpt_mem, lcpt_ctrl and layer_category_pair_table; no dependencies.
`timescale 1ns / 1ps

package lcpt_pkg;

  localparam int unsigned DEF_CAPACITY = 64;

  localparam logic [15:0] MAX_LAYER_RESET = 16'hFFFF;

  // operation codes
  localparam logic [2:0] OP_SET       = 3'd0;
  localparam logic [2:0] OP_GET       = 3'd1;
  localparam logic [2:0] OP_DEL_LAYER = 3'd2;
  localparam logic [2:0] OP_DEL_PAIR  = 3'd3;
  localparam logic [2:0] OP_RESET     = 3'd4;

  // status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_RANGE = 2'd2;

  localparam logic signed [31:0] CAT_NONE = 32'shFFFF_FFFF;

  typedef struct packed {
    logic [2:0]         op;
    logic [15:0]        layer;
    logic signed [31:0] cat_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [6:0]         match_count;
    logic signed [31:0] first_cat;
    logic [6:0]         entries_now;
  } out_item_t;

  // one stored table entry
  typedef struct packed {
    logic [15:0]        layer;
    logic signed [31:0] cat;
  } entry_t;

endpackage

>>> hdl/lcpt_mem.sv
// Entry memory of the pair table: one write port, one registered read port.
// Depends on lcpt_pkg for the entry type.
`timescale 1ns / 1ps

module lcpt_mem #(
  parameter int unsigned DEPTH = lcpt_pkg::DEF_CAPACITY,
  parameter int unsigned AW    = 6
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  lcpt_pkg::entry_t  wdata_i,
  input  logic [AW-1:0]     raddr_i,
  output lcpt_pkg::entry_t  rdata_o
);
  import lcpt_pkg::*;

  entry_t mem_q [DEPTH];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lcpt_ctrl.sv
// Sequencer of the pair table: scans the entry memory, compacts on delete,
// appends on set and builds one result per transaction. Depends on lcpt_pkg.
`timescale 1ns / 1ps

module lcpt_ctrl #(
  parameter int unsigned CAPACITY = lcpt_pkg::DEF_CAPACITY,
  parameter int unsigned AW       = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcpt_pkg::in_item_t  in_data_i,
  input  logic [15:0]         max_layer_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output lcpt_pkg::out_item_t res_o,
  output logic                mem_we_o,
  output logic [AW-1:0]       mem_waddr_o,
  output lcpt_pkg::entry_t    mem_wdata_o,
  output logic [AW-1:0]       mem_raddr_o,
  input  lcpt_pkg::entry_t    mem_rdata_i
);
  import lcpt_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      cnt_q;
  logic [CW-1:0]      lim_q;
  logic [CW-1:0]      rd_q;
  logic [CW-1:0]      wr_q;
  logic [CW-1:0]      hits_q;
  logic               pv_q;
  logic               found_q;
  logic               oor_q;
  logic               pair_cat_q;
  logic [2:0]         op_q;
  logic [15:0]        layer_q;
  logic signed [31:0] cat_q;
  logic signed [31:0] first_q;
  out_item_t          res_q;

  logic          issue;
  logic          lay_hit;
  logic          cat_hit;
  logic          del_hit;
  logic          is_del;
  logic          full;
  logic          append;
  logic          in_acc;
  logic          in_oor;
  logic          needs_scan;
  logic [CW-1:0] new_cnt;
  logic [CW-1:0] res_count;

  assign in_acc  = in_valid_i && (state_q == S_IDLE);
  assign in_oor  = (in_data_i.layer == 16'd0) || (in_data_i.layer > max_layer_i);
  assign needs_scan = (in_data_i.op == OP_SET) || (in_data_i.op == OP_DEL_LAYER) ||
                      (in_data_i.op == OP_DEL_PAIR) || ((in_data_i.op == OP_GET) && !in_oor);

  assign issue   = (state_q == S_SCAN) && (rd_q < lim_q);
  assign lay_hit = (mem_rdata_i.layer == layer_q);
  assign cat_hit = (mem_rdata_i.cat == cat_q);
  assign del_hit = lay_hit && (!pair_cat_q || cat_hit);
  assign is_del  = (op_q == OP_DEL_LAYER) || (op_q == OP_DEL_PAIR);
  assign full    = (cnt_q >= CW'(CAPACITY));
  assign append  = (state_q == S_FINISH) && (op_q == OP_SET) && !found_q && !full;

  // keep the survivors in order; write address never passes the read address
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q[AW-1:0];
    mem_wdata_o = mem_rdata_i;
    if (pv_q && is_del && !del_hit) begin
      mem_we_o = 1'b1;
    end else if (append) begin
      mem_we_o       = 1'b1;
      mem_waddr_o    = cnt_q[AW-1:0];
      mem_wdata_o.layer = layer_q;
      mem_wdata_o.cat   = cat_q;
    end
  end

  assign mem_raddr_o = rd_q[AW-1:0];

  always_comb begin
    priority if (append) begin
      new_cnt = cnt_q + CW'(1);
    end else if (is_del) begin
      new_cnt = wr_q;
    end else if (op_q == OP_RESET) begin
      new_cnt = '0;
    end else begin
      new_cnt = cnt_q;
    end
  end

  assign res_count = ((op_q == OP_GET) || is_del) ? hits_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      lim_q      <= '0;
      rd_q       <= '0;
      wr_q       <= '0;
      hits_q     <= '0;
      pv_q       <= 1'b0;
      found_q    <= 1'b0;
      oor_q      <= 1'b0;
      pair_cat_q <= 1'b0;
      op_q       <= OP_RESET;
      layer_q    <= '0;
      cat_q      <= '0;
      first_q    <= CAT_NONE;
      res_q      <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            op_q       <= in_data_i.op;
            layer_q    <= in_data_i.layer;
            cat_q      <= in_data_i.cat_value;
            pair_cat_q <= (in_data_i.op == OP_DEL_PAIR) &&
                          (in_data_i.cat_value != CAT_NONE);
            oor_q      <= (in_data_i.op == OP_GET) && in_oor;
            lim_q      <= needs_scan ? cnt_q : '0;
            rd_q       <= '0;
            wr_q       <= '0;
            hits_q     <= '0;
            pv_q       <= 1'b0;
            found_q    <= 1'b0;
            first_q    <= CAT_NONE;
            state_q    <= S_SCAN;
          end
        end
        S_SCAN: begin
          pv_q <= issue;
          if (issue) begin
            rd_q <= rd_q + CW'(1);
          end
          if (pv_q) begin
            if (op_q == OP_SET) begin
              if (lay_hit && cat_hit) begin
                found_q <= 1'b1;
              end
            end else if (op_q == OP_GET) begin
              if (lay_hit) begin
                if (hits_q == '0) begin
                  first_q <= mem_rdata_i.cat;
                end
                hits_q <= hits_q + CW'(1);
              end
            end else if (del_hit) begin
              hits_q <= hits_q + CW'(1);
            end else begin
              wr_q <= wr_q + CW'(1);
            end
          end
          if (!issue && !pv_q) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          cnt_q <= new_cnt;
          priority if (oor_q) begin
            res_q.status <= STATUS_RANGE;
          end else if ((op_q == OP_SET) && !found_q && full) begin
            res_q.status <= STATUS_FULL;
          end else begin
            res_q.status <= STATUS_OK;
          end
          res_q.match_count <= 7'(res_count);
          res_q.first_cat   <= first_q;
          res_q.entries_now <= 7'(new_cnt);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (res_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

endmodule

>>> hdl/layer_category_pair_table.sv
// Top level of the layer/category pair table: config register, output stage.
// Depends on lcpt_pkg, lcpt_mem and lcpt_ctrl.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_stall_o / in_data_i): one operation per
//   transaction - set pair, get layer, delete layer, delete pair or reset.
//   Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//   result per operation, in order.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_data_i): writes max_layer;
//   always ready, write it only while no operation is in flight.
// Timing
//   An operation scans the stored entries one per cycle through the single
//   read port of the entry memory; the result is then built in the finish
//   state and lands in the output register, and the next operation is taken
//   in the following cycle. Deletes compact within the scan.
// Reset
//   The table is empty and max_layer is 65535. Memory contents are not cleared.
// Stall
//   A result waits in the output register; the next operation may still be
//   accepted and run, and finishes once the output register frees up.
module layer_category_pair_table #(
  parameter int unsigned CAPACITY = lcpt_pkg::DEF_CAPACITY
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lcpt_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lcpt_pkg::out_item_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_data_i
);
  import lcpt_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic        [15:0] max_layer_q;
  logic               out_valid_q;
  out_item_t          out_data_q;
  logic               res_valid;
  logic               res_ready;
  out_item_t          res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  entry_t             mem_wdata;
  logic [AW-1:0]      mem_raddr;
  entry_t             mem_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_layer_q <= MAX_LAYER_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_layer_q <= cfg_data_i;
    end
  end

  lcpt_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lcpt_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .max_layer_i (max_layer_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // load a new result when the register is empty or being drained
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
